// ----- sv/atw_pkg.sv -----
// ----------------------------------------------------------------------------
// atw_pkg
// Types and constants for the ANSI text terminal writer.
// ----------------------------------------------------------------------------
`default_nettype none
package atw_pkg;
  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int AW      = $clog2(CELLS);

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] host_byte;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,    // clearing pass after reset
    ST_IDLE,
    ST_READ,    // wait for read data of a cell read
    ST_CLEAR,   // write zeros over a range
    ST_SCR_RD,  // scroll: read source cell
    ST_SCR_WR,  // scroll: write it one line up
    ST_OUT      // hold result until taken
  } state_t;
endpackage
`default_nettype wire

// ----- sv/ansi_text_terminal_writer.sv -----
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer
// Character-cell terminal driven by a host byte stream with ESC [ decoding.
// ----------------------------------------------------------------------------
// Timing: for bytes that need no store pass the result is valid in the cycle
// after the input transfer; a cell read passes through ST_READ first. A clear
// adds an ST_CLEAR step per cleared cell; a scroll adds ST_SCR_RD and ST_SCR_WR
// per moved cell plus an ST_CLEAR step per cleared cell. One item at a time.
// Reset: synchronous, active low; a clearing pass in ST_INIT zeros the
// store before the first item is accepted.
`default_nettype none
module ansi_text_terminal_writer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire atw_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output atw_pkg::out_item_t        out_data
);
  import atw_pkg::*;

  localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);
  localparam logic [AW-1:0] LASTLN = AW'(CELLS - COLUMNS);
  localparam logic [6:0]    CMAX   = 7'(COLUMNS - 1);
  localparam logic [4:0]    RMAX   = 5'(ROWS - 1);

  state_t state_r, state_nxt;
  logic [6:0] col_r, col_nxt;
  logic [4:0] row_r, row_nxt;
  logic esc_r, esc_nxt, csi_r, csi_nxt, osc_r, osc_nxt;
  logic [7:0] n1_r, n1_nxt, n2_r, n2_nxt;
  logic slot_r, slot_nxt, dig_r, dig_nxt, priv_r, priv_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt, end_r, end_nxt;
  logic [7:0] cell_r, cell_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;

  atw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic accept;
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = '{cell_char: cell_r, cur_col: col_r, cur_row: row_r};

  // Decode helpers
  logic [7:0]    c;
  logic [AW-1:0] here, line;
  logic [7:0]    n;
  logic [7:0]    sat;
  logic [7:0]    cur_num;
  assign c    = in_data.host_byte;
  assign here = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign line = AW'(row_r) * AW'(COLUMNS);
  assign n    = (n1_r == 8'd0) ? 8'd1 : n1_r;
  assign cur_num = slot_r ? n2_r : n1_r;
  always_comb begin
    logic [12:0] t;
    t   = 13'(cur_num) * 13'd10 + 13'(c - 8'h30);
    sat = (t > 13'd255) ? 8'd255 : t[7:0];
  end

  always_comb begin
    logic [7:0] t8;
    logic       scroll;
    state_nxt = state_r;
    col_nxt = col_r; row_nxt = row_r;
    esc_nxt = esc_r; csi_nxt = csi_r; osc_nxt = osc_r;
    n1_nxt = n1_r; n2_nxt = n2_r; slot_nxt = slot_r; dig_nxt = dig_r; priv_nxt = priv_r;
    ptr_nxt = ptr_r; end_nxt = end_r; cell_nxt = cell_r;
    we = 1'b0; addr = ptr_r; wdata = 8'd0;
    scroll = 1'b0;
    t8 = 8'd0;
    unique case (state_r)
      ST_INIT: begin
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cell_nxt  = 8'd0;
          state_nxt = ST_OUT;
          if (in_data.opcode == OP_READ) begin
            if (in_data.read_row < 5'(ROWS) && in_data.read_col < 7'(COLUMNS)) begin
              addr = AW'(in_data.read_row) * AW'(COLUMNS) + AW'(in_data.read_col);
              state_nxt = ST_READ;
            end
          end else if (osc_r) begin
            if (c == 8'd7) osc_nxt = 1'b0;
          end else if (csi_r) begin
            if (c >= 8'h30 && c <= 8'h39) begin
              if (slot_r) n2_nxt = sat; else n1_nxt = sat;
              dig_nxt = 1'b1;
            end else if (c == 8'h3b) begin
              slot_nxt = 1'b1;
            end else if (c >= 8'h3a && c <= 8'h3f) begin
              priv_nxt = 1'b1;
            end else if (c >= 8'h40 && c <= 8'h7e) begin
              csi_nxt = 1'b0;
              n1_nxt = 8'd0; n2_nxt = 8'd0; slot_nxt = 1'b0;
              dig_nxt = 1'b0; priv_nxt = 1'b0;
              if (!priv_r) begin
                case (c)
                  "A", "F": begin
                    row_nxt = (n > 8'(row_r)) ? 5'd0 : 5'(8'(row_r) - n);
                    if (c == "F") col_nxt = 7'd0;
                  end
                  "B", "E": begin
                    row_nxt = (9'(row_r) + 9'(n) >= 9'(ROWS)) ? RMAX : 5'(9'(row_r) + 9'(n));
                    if (c == "E") col_nxt = 7'd0;
                  end
                  "C": col_nxt = (9'(col_r) + 9'(n) >= 9'(COLUMNS)) ? CMAX
                                 : 7'(9'(col_r) + 9'(n));
                  "D": col_nxt = (n > 8'(col_r)) ? 7'd0 : 7'(8'(col_r) - n);
                  "G": col_nxt = (9'(n) > 9'(COLUMNS)) ? CMAX : 7'(n - 8'd1);
                  "H": begin
                    row_nxt = (9'(n) > 9'(ROWS)) ? RMAX : 5'(n - 8'd1);
                    t8 = (n2_r == 8'd0) ? 8'd1 : n2_r;
                    col_nxt = (9'(t8) > 9'(COLUMNS)) ? CMAX : 7'(t8 - 8'd1);
                  end
                  "J": begin
                    if (n1_r == 8'd0) begin
                      ptr_nxt = here; end_nxt = LAST; state_nxt = ST_CLEAR;
                    end else if (n1_r == 8'd1) begin
                      ptr_nxt = '0; end_nxt = here; state_nxt = ST_CLEAR;
                    end else if (n1_r == 8'd2 || n1_r == 8'd3) begin
                      ptr_nxt = '0; end_nxt = LAST; state_nxt = ST_CLEAR;
                    end
                  end
                  "K": begin
                    if (n1_r == 8'd0) begin
                      ptr_nxt = here; end_nxt = line + AW'(COLUMNS - 1);
                      state_nxt = ST_CLEAR;
                    end else if (n1_r == 8'd1) begin
                      ptr_nxt = line; end_nxt = here; state_nxt = ST_CLEAR;
                    end else if (n1_r == 8'd2) begin
                      ptr_nxt = line; end_nxt = line + AW'(COLUMNS - 1);
                      state_nxt = ST_CLEAR;
                    end
                  end
                  default: ;
                endcase
              end
            end
          end else if (esc_r && c == "[") begin
            esc_nxt = 1'b0; csi_nxt = 1'b1;
            n1_nxt = 8'd0; n2_nxt = 8'd0; slot_nxt = 1'b0;
            dig_nxt = 1'b0; priv_nxt = 1'b0;
          end else if (esc_r && c == "]") begin
            esc_nxt = 1'b0; osc_nxt = 1'b1;
          end else begin
            esc_nxt = (c == 8'd27);
            if (c == 8'd8) begin
              if (col_r != 7'd0) col_nxt = col_r - 7'd1;
              else if (row_r != 5'd0) begin
                col_nxt = CMAX; row_nxt = row_r - 5'd1;
              end
            end else if (c == 8'd9) begin
              if (8'({col_r[6:3], 3'b000}) + 8'd8 >= 8'(COLUMNS)) begin
                col_nxt = 7'd0; scroll = 1'b1;
              end else col_nxt = {col_r[6:3] + 4'd1, 3'b000};
            end else if (c == 8'd10) begin
              scroll = 1'b1;
            end else if (c == 8'd13) begin
              col_nxt = 7'd0;
            end else if (c >= 8'd32 && c <= 8'd126) begin
              we = 1'b1; addr = here; wdata = c;
              if (col_r == CMAX) begin
                col_nxt = 7'd0; scroll = 1'b1;
              end else col_nxt = col_r + 7'd1;
            end
            // advance line, or start a scroll on the last line
            if (scroll) begin
              if (row_r != RMAX) row_nxt = row_r + 5'd1;
              else begin
                ptr_nxt = AW'(COLUMNS); state_nxt = ST_SCR_RD;
              end
            end
          end
        end
      end
      ST_READ: begin
        cell_nxt  = rdata;
        state_nxt = ST_OUT;
      end
      ST_CLEAR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == end_r) state_nxt = ST_OUT;
      end
      ST_SCR_RD: begin
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        we = 1'b1; addr = ptr_r - AW'(COLUMNS); wdata = rdata;
        if (ptr_r == LAST) begin
          ptr_nxt = LASTLN; end_nxt = LAST; state_nxt = ST_CLEAR;
        end else begin
          ptr_nxt = ptr_r + 1'b1; state_nxt = ST_SCR_RD;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      col_r <= '0; row_r <= '0;
      esc_r <= 1'b0; csi_r <= 1'b0; osc_r <= 1'b0;
      n1_r <= '0; n2_r <= '0; slot_r <= 1'b0; dig_r <= 1'b0; priv_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt; row_r <= row_nxt;
      esc_r <= esc_nxt; csi_r <= csi_nxt; osc_r <= osc_nxt;
      n1_r <= n1_nxt; n2_r <= n2_nxt; slot_r <= slot_nxt;
      dig_r <= dig_nxt; priv_r <= priv_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r  <= end_nxt;
    cell_r <= cell_nxt;
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < 7'(COLUMNS)) && (row_r < 5'(ROWS)))
    else $error("cursor out of screen");
  a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({csi_r, osc_r}) <= 1)
    else $error("parser in two modes");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_SCR_RD || state_r == ST_SCR_WR) |-> !in_ready)
    else $error("accepting while store busy");
  a_read_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_OUT))
    else $error("read did not complete");
endmodule
`default_nettype wire

// ----- sv/atw_ram.sv -----
// ----------------------------------------------------------------------------
// atw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module atw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- dv/ansi_text_terminal_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ansi_text_terminal_writer_tb
// Drives host bytes and cell reads into the terminal writer and checks every
// result against a cycle-free screen model kept in the testbench: cursor
// moves, wrap, scroll, escape and OSC parsing, clears and stored cells.
// ----------------------------------------------------------------------------
module ansi_text_terminal_writer_tb;
  import atw_pkg::*;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_ESC = 8'h1b;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  ansi_text_terminal_writer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // screen model
  logic [7:0] screen [CELLS];
  int  cur_x, cur_y, num_a, num_b;
  bit  esc_pend, in_csi, in_osc, second_slot, got_digits, is_private;

  out_item_t pending_results [$];
  int errors = 0;
  int bytes_fed = 0, cells_read = 0, scrolls = 0;
  int snd_idle = 0, rcv_idle = 0, hold_cycles = 0;

  function automatic void blank(int from, int to_excl);
    for (int i = from; i < to_excl && i < CELLS; i++) screen[i] = 8'h00;
  endfunction

  function automatic void line_feed();
    if (cur_y + 1 < ROWS) begin
      cur_y++;
    end else begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      blank(CELLS - COLUMNS, CELLS);
      scrolls++;
    end
  endfunction

  function automatic int pos_clamp(int v, int lim);
    if (v == 0) v = 1;
    return (v > lim ? lim : v) - 1;
  endfunction

  function automatic void run_final(int c);
    int n, here, row0;
    n = (num_a == 0) ? 1 : num_a;
    here = cur_y * COLUMNS + cur_x;
    row0 = cur_y * COLUMNS;
    case (c)
      "A", "F": begin
        cur_y = (n > cur_y) ? 0 : cur_y - n;
        if (c == "F") cur_x = 0;
      end
      "B", "E": begin
        cur_y = (cur_y + n >= ROWS) ? ROWS - 1 : cur_y + n;
        if (c == "E") cur_x = 0;
      end
      "C": cur_x = (cur_x + n >= COLUMNS) ? COLUMNS - 1 : cur_x + n;
      "D": cur_x = (n > cur_x) ? 0 : cur_x - n;
      "G": cur_x = pos_clamp(num_a, COLUMNS);
      "H": begin
        cur_y = pos_clamp(num_a, ROWS);
        cur_x = pos_clamp(num_b, COLUMNS);
      end
      "J": begin
        if (num_a == 0) blank(here, CELLS);
        else if (num_a == 1) blank(0, here + 1);
        else if (num_a == 2 || num_a == 3) blank(0, CELLS);
      end
      "K": begin
        if (num_a == 0) blank(here, row0 + COLUMNS);
        else if (num_a == 1) blank(row0, here + 1);
        else if (num_a == 2) blank(row0, row0 + COLUMNS);
      end
      default: ;
    endcase
  endfunction

  function automatic void reset_params();
    num_a = 0; num_b = 0; second_slot = 0; got_digits = 0; is_private = 0;
  endfunction

  function automatic void csi_byte(int c);
    int v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = (second_slot ? num_b : num_a) * 10 + (c - 8'h30);
      if (v > 255) v = 255;
      if (second_slot) num_b = v; else num_a = v;
      got_digits = 1;
    end else if (c == 8'h3b) begin
      second_slot = 1;
    end else if (c >= 8'h3a && c <= 8'h3f) begin
      is_private = 1;
    end else if (c >= 8'h40 && c <= 8'h7e) begin
      if (!is_private) run_final(c);
      in_csi = 0;
      reset_params();
    end
  endfunction

  function automatic void host_byte_in(int c);
    int t;
    if (in_osc) begin
      if (c == CH_BEL) in_osc = 0;
      return;
    end
    if (in_csi) begin
      csi_byte(c);
      return;
    end
    if (esc_pend && c == "[") begin
      esc_pend = 0; in_csi = 1; reset_params();
      return;
    end
    if (esc_pend && c == "]") begin
      esc_pend = 0; in_osc = 1;
      return;
    end
    esc_pend = (c == CH_ESC);
    if (c == CH_BS) begin
      if (cur_x > 0) begin
        cur_x--;
      end else if (cur_y > 0) begin
        cur_x = COLUMNS - 1; cur_y--;
      end
    end else if (c == CH_HT) begin
      t = (cur_x / 8 + 1) * 8;
      if (t >= COLUMNS) begin
        cur_x = 0; line_feed();
      end else begin
        cur_x = t;
      end
    end else if (c == CH_LF) begin
      line_feed();
    end else if (c == CH_CR) begin
      cur_x = 0;
    end else if (c >= 32 && c <= 126) begin
      screen[cur_y * COLUMNS + cur_x] = c[7:0];
      if (cur_x + 1 >= COLUMNS) begin
        cur_x = 0; line_feed();
      end else begin
        cur_x++;
      end
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.opcode == OP_FEED) begin
      host_byte_in(it.host_byte);
    end else if (it.read_row < ROWS && it.read_col < COLUMNS) begin
      r.cell_char = screen[it.read_row * COLUMNS + it.read_col];
    end
    r.cur_col = cur_x[6:0];
    r.cur_row = cur_y[4:0];
    return r;
  endfunction

  // drive one item at the falling edge and hold it until transfer
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(it));
    if (it.opcode == OP_FEED) bytes_fed++; else cells_read++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic feed(logic [7:0] b);
    in_item_t it;
    it = '0;
    it.opcode = OP_FEED;
    it.host_byte = b;
    it.read_row = 5'($urandom);
    it.read_col = 7'($urandom);
    send_item(it);
  endtask

  task automatic feed_str(string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  task automatic read_cell(logic [4:0] r, logic [6:0] c);
    in_item_t it;
    it = '0;
    it.opcode = OP_READ;
    it.host_byte = 8'($urandom);
    it.read_row = r;
    it.read_col = c;
    send_item(it);
  endtask

  // receiver: random stall or a counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready = ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: actual %p", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.cell_char !== out_data.cell_char) begin
          errors++;
          $display("%0t: cell_char expected %h actual %h", $time,
                   want.cell_char, out_data.cell_char);
        end
        if (want.cur_col !== out_data.cur_col) begin
          errors++;
          $display("%0t: cur_col expected %0d actual %0d", $time,
                   want.cur_col, out_data.cur_col);
        end
        if (want.cur_row !== out_data.cur_row) begin
          errors++;
          $display("%0t: cur_row expected %0d actual %0d", $time,
                   want.cur_row, out_data.cur_row);
        end
      end
    end
  end

  task automatic test_directed();
    feed(CH_BS);                      // backspace at top-left
    feed(8'h20); feed(8'h7e);
    read_cell(5'd0, 7'd1);
    read_cell(5'd31, 7'd127);         // out of range
    read_cell(5'd23, 7'd80);
    feed(CH_HT); feed(CH_CR); feed(CH_LF); feed(8'hff);
    feed(CH_ESC); feed_str("[24;80H");
    feed("Z");                        // last cell: wrap and scroll
    feed(CH_ESC); feed_str("[999C");  // saturating count
    feed(CH_ESC); feed_str("]x");
    feed(CH_BEL);
    feed(CH_ESC); feed_str("[?5A");
    feed(CH_ESC); feed_str("[1K");
    feed(CH_ESC); feed_str("[2J");
  endtask

  task automatic random_csi();
    string s;
    int k;
    string finals;
    finals = "ABCDEFGHJKmsz@~";
    s = "[";
    if ($urandom_range(9) == 0) s = {s, "?"};
    k = $urandom_range(9);
    if (k < 7) s = {s, $sformatf("%0d", (k < 5) ? $urandom_range(30) : $urandom_range(400))};
    if ($urandom_range(2) == 0) s = {s, $sformatf(";%0d", $urandom_range(90))};
    if ($urandom_range(19) == 0) s = {s, " "};
    k = $urandom_range(finals.len() - 1);
    s = {s, finals.substr(k, k)};
    feed(CH_ESC);
    feed_str(s);
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 40) begin
      feed(8'($urandom_range(8'h20, 8'h7e)));
    end else if (k < 60) begin
      if ($urandom_range(4) == 0) read_cell(5'($urandom), 7'($urandom));
      else read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLUMNS - 1)));
    end else if (k < 78) begin
      random_csi();
    end else if (k < 86) begin
      case ($urandom_range(3))
        0: feed(CH_BS);
        1: feed(CH_HT);
        2: feed(CH_LF);
        default: feed(CH_CR);
      endcase
    end else if (k < 89) begin
      feed(CH_ESC); feed("]");
      repeat ($urandom_range(4)) feed(8'($urandom));
      feed(CH_BEL);
    end else begin
      feed(8'($urandom));
    end
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    int stop_at;
    snd_idle = s_idle;
    rcv_idle = r_idle;
    stop_at = bytes_fed + cells_read + count;
    while (bytes_fed + cells_read < stop_at) random_item();
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_idle = 0;
    @(negedge clk);
    hold_cycles = 400;
    repeat (20) random_item();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) screen[i] = 8'h00;
    cur_x = 0; cur_y = 0;
    esc_pend = 0; in_csi = 0; in_osc = 0;
    reset_params();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(500, 23, 59);
    test_random(500, 59, 23);
    test_random(500, 0, 0);
    test_backpressure();
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("Fed %0d host bytes and %0d cell reads; %0d scrolls predicted.",
             bytes_fed, cells_read, scrolls);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #240000000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ----- ansi_text_terminal_writer.f -----
sv/atw_pkg.sv
sv/atw_ram.sv
sv/ansi_text_terminal_writer.sv
dv/ansi_text_terminal_writer_tb.sv
